[rtl/crg_pkg.sv]
// ============================================================================
// crg_pkg - camera ray generator shared definitions
// Widths, register indexes, reset values and pipeline payload types.
// ============================================================================
package crg_pkg;

    // Input coordinate width and Q format of the canvas and matrix words
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam int IN_W   = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int WORD_W = 32;
    localparam int OUT_W  = 6 * WORD_W;

    localparam int NUM_REGS   = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    // Canvas arithmetic: (2*idx+1)*pitch and 2*half - that product
    localparam int PC_W     = COORD_BITS + 33;
    localparam int CANVAS_W = COORD_BITS + 35;

    // Normalization and division widths
    localparam int MAG_W  = 64;
    localparam int LEN_W  = 7;
    localparam int NORM_W = 30;
    localparam int SQ_W   = 62;
    localparam int ROOT_W = 31;
    localparam int NUM_W  = 61;
    localparam int Q_W    = 31;

    localparam logic [WORD_W-1:0] ONE_Q   = 32'd1 << FRAC_BITS;
    localparam logic [Q_W-1:0]    DIR_ONE = 31'd1 << 30;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROW0_XY = 3'd0,
        REG_ROW0_ZW = 3'd1,
        REG_ROW1_XY = 3'd2,
        REG_ROW1_ZW = 3'd3,
        REG_ROW2_XY = 3'd4,
        REG_ROW2_ZW = 3'd5,
        REG_PITCH   = 3'd6,
        REG_HALF    = 3'd7
    } cfg_idx_t;

    // Camera set-up as decoded from the register file
    typedef struct packed {
        logic [2:0][3:0][WORD_W-1:0] m;
        logic [WORD_W-1:0]           pitch;
        logic [WORD_W-1:0]           half_w;
        logic [WORD_W-1:0]           half_h;
    } cam_cfg_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } side_t;

    typedef struct packed {
        logic [2:0][NORM_W-1:0] mag;
        side_t                  side;
    } norm_pipe_t;

    typedef struct packed {
        logic [SQ_W-1:0] sum_sq;
        norm_pipe_t      pipe;
    } front_out_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        norm_pipe_t        pipe;
    } root_out_t;

    typedef struct packed {
        logic [2:0][WORD_W-1:0] dir;
        logic                   degen;
    } result_t;

endpackage

[rtl/camera_ray_generator.sv]
// ============================================================================
// camera_ray_generator - pinhole camera primary ray generation
// Pixel coordinates in, world-space ray origin and unit direction out.
// ============================================================================
// Usage:
//   s_ channel: one transfer per pixel, s_tdata = {pixel_row, pixel_col}.
//   m_ channel: one transfer per pixel in input order, m_tdata carries the
//   ray origin (Q16.16) and unit direction (Q2.30), m_tuser the degenerate
//   flag (zero-length direction, direction then forced to zero).
//   cfg_ port: write-only register file holding the inverse camera transform,
//   pixel pitch and canvas half extents; write only while no pixel is in flight.
// Throughput: one pixel per cycle, sustained while the skid register stays free.
// Pipeline: a 10-stage front end, a 31-stage square root, a numerator stage,
//   31-stage dividers and the output register; the root and divide pipelines
//   resolve one bit per stage.
// Reset: synchronous, active low; clears the pipeline and loads the identity
//   transform, unit pitch and zero half extents.
// Stall: an output register plus a skid register part the channels; the
//   pipeline keeps moving while one result waits and holds (s_tready low)
//   only once the skid register is also occupied. Nothing is lost or repeated.
// ============================================================================
module camera_ray_generator
    import crg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,  // pixel_col, pixel_row
    // ray output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    output logic                  m_tuser   // degenerate
);

    cam_cfg_t   cfg;
    logic       en;
    logic       front_valid, root_valid;
    front_out_t front_data;
    root_out_t  root_data;

    // numerator stage
    logic             num_v_reg;
    logic [NUM_W-1:0] num_reg [3];
    logic [ROOT_W-1:0] den_reg;
    side_t            num_side_reg;

    // side band alongside the dividers
    logic [Q_W-1:0] div_v_reg;
    side_t          div_side_reg [Q_W];
    logic [Q_W-1:0] quot [3];

    // output register and skid register
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    result_t res_next;
    logic    arrive, pop;

    // the pipeline advances whenever the skid register is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    crg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    crg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .pixel_col (s_tdata[COORD_BITS-1:0]),
        .pixel_row (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .cfg       (cfg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    crg_isqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (root_valid),
        .out_data  (root_data)
    );

    // numerator |e| * 2^30 + L/2 for round-half-up division
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_v_reg <= 1'b0;
        end else if (en) begin
            num_v_reg <= root_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= NUM_W'({root_data.pipe.mag[i], 30'd0})
                            + NUM_W'(root_data.root[ROOT_W-1:1]);
            end
            den_reg      <= root_data.root;
            num_side_reg <= root_data.pipe.side;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        crg_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (num_reg[i]),
            .den  (den_reg),
            .quot (quot[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_v_reg <= '0;
        end else if (en) begin
            div_v_reg <= {div_v_reg[Q_W-2:0], num_v_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_side_reg[0] <= num_side_reg;
            for (int i = 1; i < Q_W; i++) begin
                div_side_reg[i] <= div_side_reg[i-1];
            end
        end
    end

    // clamp to 1.0, apply sign, zero on degenerate
    always_comb begin
        logic [Q_W-1:0] qc;
        qc = '0;
        for (int i = 0; i < 3; i++) begin
            qc = (quot[i] > DIR_ONE) ? DIR_ONE : quot[i];
            if (div_side_reg[Q_W-1].degen) begin
                res_next.dir[i] = '0;
            end else if (div_side_reg[Q_W-1].neg[i]) begin
                res_next.dir[i] = -{1'b0, qc};
            end else begin
                res_next.dir[i] = {1'b0, qc};
            end
        end
        res_next.degen = div_side_reg[Q_W-1].degen;
    end

    assign arrive = en && div_v_reg[Q_W-1];
    assign pop    = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || pop) begin
            out_valid_reg <= arrive;
        end else if (arrive) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || pop) begin
            out_reg <= res_next;
        end else begin
            skid_reg <= res_next;
        end
    end

    // origins are the translation column, stable while pixels are in flight
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.dir[2], out_reg.dir[1], out_reg.dir[0],
                       cfg.m[2][3], cfg.m[1][3], cfg.m[0][3]};
    assign m_tuser  = out_reg.degen;

    // skid register only fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds data while output is empty");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.degen) |->
            (out_reg.dir[0] == '0 && out_reg.dir[1] == '0 && out_reg.dir[2] == '0))
        else $error("degenerate ray with nonzero direction");

    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
            ($signed(out_reg.dir[0]) <= 32'sd1073741824 &&
             $signed(out_reg.dir[0]) >= -32'sd1073741824 &&
             $signed(out_reg.dir[1]) <= 32'sd1073741824 &&
             $signed(out_reg.dir[1]) >= -32'sd1073741824 &&
             $signed(out_reg.dir[2]) <= 32'sd1073741824 &&
             $signed(out_reg.dir[2]) >= -32'sd1073741824))
        else $error("direction component exceeds unit magnitude");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && pop) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid register did not drain into output");

endmodule

[rtl/crg_cfg_regs.sv]
// ============================================================================
// crg_cfg_regs - configuration register file
// Eight 64-bit registers with write-only access, decoded into the camera set-up.
// ============================================================================
module crg_cfg_regs
    import crg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cam_cfg_t              cfg
);

    logic [CFG_DATA_W-1:0] regs_reg [NUM_REGS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[REG_ROW0_XY] <= {ONE_Q, 32'd0};
            regs_reg[REG_ROW0_ZW] <= '0;
            regs_reg[REG_ROW1_XY] <= {32'd0, ONE_Q};
            regs_reg[REG_ROW1_ZW] <= '0;
            regs_reg[REG_ROW2_XY] <= '0;
            regs_reg[REG_ROW2_ZW] <= {ONE_Q, 32'd0};
            regs_reg[REG_PITCH]   <= {32'd0, ONE_Q};
            regs_reg[REG_HALF]    <= '0;
        end else if (cfg_wr_en) begin
            regs_reg[cfg_addr] <= cfg_wdata;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            cfg.m[r][0] = regs_reg[2*r][63:32];
            cfg.m[r][1] = regs_reg[2*r][31:0];
            cfg.m[r][2] = regs_reg[2*r+1][63:32];
            cfg.m[r][3] = regs_reg[2*r+1][31:0];
        end
        cfg.pitch  = regs_reg[REG_PITCH][31:0];
        cfg.half_w = regs_reg[REG_HALF][63:32];
        cfg.half_h = regs_reg[REG_HALF][31:0];
    end

endmodule

[rtl/crg_front.sv]
// ============================================================================
// crg_front - canvas point, camera transform and normalization front end
// Ten stages: pitch products, canvas, matrix products, sum, magnitude, leading one, shift, squares, sum of squares.
// ============================================================================
module crg_front
    import crg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [COORD_BITS-1:0] pixel_col,
    input  logic [COORD_BITS-1:0] pixel_row,
    input  cam_cfg_t              cfg,
    output logic                  out_valid,
    output front_out_t            out_data
);

    logic [9:0] v_reg;

    // stage 1: (2*idx+1)*pitch
    logic [PC_W-1:0] pcx_reg, pcy_reg;
    // stage 2: canvas point
    logic signed [WORD_W-1:0] w_reg [2];
    // stage 3: products
    logic signed [63:0] p_reg [3][3];
    // stage 4: transformed direction
    logic signed [63:0] d_reg [3];
    // stage 5..7
    logic [MAG_W-1:0] mag5_reg [3], mag6_reg [3], mag7_reg [3];
    logic [MAG_W-1:0] or5_reg;
    logic [2:0]       neg5_reg, neg6_reg, neg7_reg, neg8_reg, neg9_reg, neg10_reg;
    logic [7:0]       nz6_reg;
    logic [2:0]       pos6_reg [8];
    logic [LEN_W-1:0] len7_reg;
    logic             degen7_reg, degen8_reg, degen9_reg, degen10_reg;
    // stage 8..10
    logic [NORM_W-1:0]   norm8_reg [3], norm9_reg [3], norm10_reg [3];
    logic [2*NORM_W-1:0] sq9_reg [3];
    logic [SQ_W-1:0]     sum10_reg;

    logic signed [CANVAS_W-1:0] t_x, t_y;
    logic signed [WORD_W-1:0]   w_x_next, w_y_next;
    logic [MAG_W-1:0]           mag_next [3];
    logic [7:0]                 nz_next;
    logic [2:0]                 pos_next [8];
    logic [LEN_W-1:0]           len_next;
    logic [NORM_W-1:0]          norm_next [3];

    function automatic logic signed [WORD_W-1:0] canvas_sat(
        input logic signed [CANVAS_W-1:0] t
    );
        logic signed [CANVAS_W-1:0] h;
        h = (t + $signed(CANVAS_W'(1))) >>> 1;
        if (h > $signed({{(CANVAS_W-31){1'b0}}, {31{1'b1}}})) begin
            return 32'sh7fffffff;
        end else if (h < $signed({{(CANVAS_W-31){1'b1}}, 31'd0})) begin
            return 32'sh80000000;
        end
        return h[WORD_W-1:0];
    endfunction

    always_comb begin
        t_x = ($signed({{(CANVAS_W-32){cfg.half_w[31]}}, cfg.half_w}) <<< 1)
            - $signed(CANVAS_W'(pcx_reg));
        t_y = ($signed({{(CANVAS_W-32){cfg.half_h[31]}}, cfg.half_h}) <<< 1)
            - $signed(CANVAS_W'(pcy_reg));
        w_x_next = canvas_sat(t_x);
        w_y_next = canvas_sat(t_y);

        for (int i = 0; i < 3; i++) begin
            mag_next[i] = d_reg[i][63] ? (~d_reg[i] + 64'd1) : d_reg[i];
        end

        for (int g = 0; g < 8; g++) begin
            nz_next[g]  = |or5_reg[8*g +: 8];
            pos_next[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (or5_reg[8*g+b]) begin
                    pos_next[g] = 3'(b);
                end
            end
        end

        len_next = '0;
        for (int g = 0; g < 8; g++) begin
            if (nz6_reg[g]) begin
                len_next = LEN_W'(g * 8) + LEN_W'(pos6_reg[g]) + LEN_W'(1);
            end
        end

        for (int i = 0; i < 3; i++) begin
            if (len7_reg > LEN_W'(NORM_W)) begin
                norm_next[i] = NORM_W'(mag7_reg[i] >> (len7_reg - LEN_W'(NORM_W)));
            end else begin
                norm_next[i] = NORM_W'(mag7_reg[i] << (LEN_W'(NORM_W) - len7_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[8:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pcx_reg <= PC_W'({pixel_col, 1'b1}) * PC_W'(cfg.pitch);
            pcy_reg <= PC_W'({pixel_row, 1'b1}) * PC_W'(cfg.pitch);

            w_reg[0] <= w_x_next;
            w_reg[1] <= w_y_next;

            for (int i = 0; i < 3; i++) begin
                p_reg[i][0] <= $signed(cfg.m[i][0]) * w_reg[0];
                p_reg[i][1] <= $signed(cfg.m[i][1]) * w_reg[1];
                // third canvas coordinate is -1.0
                p_reg[i][2] <= -($signed({{32{cfg.m[i][2][31]}}, cfg.m[i][2]}) <<< FRAC_BITS);
            end

            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= (p_reg[i][0] >>> 2) + (p_reg[i][1] >>> 2) + (p_reg[i][2] >>> 2);
            end

            for (int i = 0; i < 3; i++) begin
                mag5_reg[i] <= mag_next[i];
                neg5_reg[i] <= d_reg[i][63];
            end
            or5_reg <= mag_next[0] | mag_next[1] | mag_next[2];

            mag6_reg <= mag5_reg;
            neg6_reg <= neg5_reg;
            nz6_reg  <= nz_next;
            pos6_reg <= pos_next;

            mag7_reg   <= mag6_reg;
            neg7_reg   <= neg6_reg;
            len7_reg   <= len_next;
            degen7_reg <= ~|nz6_reg;

            norm8_reg  <= norm_next;
            neg8_reg   <= neg7_reg;
            degen8_reg <= degen7_reg;

            for (int i = 0; i < 3; i++) begin
                sq9_reg[i] <= norm8_reg[i] * norm8_reg[i];
            end
            norm9_reg  <= norm8_reg;
            neg9_reg   <= neg8_reg;
            degen9_reg <= degen8_reg;

            sum10_reg <= SQ_W'(sq9_reg[0]) + SQ_W'(sq9_reg[1]) + SQ_W'(sq9_reg[2]);
            norm10_reg  <= norm9_reg;
            neg10_reg   <= neg9_reg;
            degen10_reg <= degen9_reg;
        end
    end

    always_comb begin
        out_valid                = v_reg[9];
        out_data.sum_sq          = sum10_reg;
        for (int i = 0; i < 3; i++) begin
            out_data.pipe.mag[i] = norm10_reg[i];
        end
        out_data.pipe.side.neg   = neg10_reg;
        out_data.pipe.side.degen = degen10_reg;
    end

endmodule

[rtl/crg_isqrt.sv]
// ============================================================================
// crg_isqrt - pipelined integer square root
// One root bit per stage, remainder form; carries the normalized vector along.
// ============================================================================
module crg_isqrt
    import crg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  front_out_t in_data,
    output logic       out_valid,
    output root_out_t  out_data
);

    logic [ROOT_W-1:0] v_reg;
    logic [SQ_W-1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    norm_pipe_t        pipe_reg [ROOT_W];

    logic [SQ_W-1:0]   rem_cur  [ROOT_W];
    logic [ROOT_W-1:0] root_cur [ROOT_W];
    norm_pipe_t        pipe_cur [ROOT_W];
    logic [63:0]       trial    [ROOT_W];
    logic              take     [ROOT_W];

    always_comb begin
        for (int i = 0; i < ROOT_W; i++) begin
            if (i == 0) begin
                rem_cur[i]  = in_data.sum_sq;
                root_cur[i] = '0;
                pipe_cur[i] = in_data.pipe;
            end else begin
                rem_cur[i]  = rem_reg[i-1];
                root_cur[i] = root_reg[i-1];
                pipe_cur[i] = pipe_reg[i-1];
            end
            // (r + 2^b)^2 - r^2
            trial[i] = (64'(root_cur[i]) << (ROOT_W - i))
                     | (64'd1 << (2 * (ROOT_W - 1 - i)));
            take[i]  = 64'(rem_cur[i]) >= trial[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[ROOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < ROOT_W; i++) begin
                rem_reg[i]  <= take[i] ? SQ_W'(64'(rem_cur[i]) - trial[i]) : rem_cur[i];
                root_reg[i] <= take[i] ? (root_cur[i] | (ROOT_W'(1) << (ROOT_W - 1 - i)))
                                       : root_cur[i];
                pipe_reg[i] <= pipe_cur[i];
            end
        end
    end

    assign out_valid     = v_reg[ROOT_W-1];
    assign out_data.root = root_reg[ROOT_W-1];
    assign out_data.pipe = pipe_reg[ROOT_W-1];

endmodule

[rtl/crg_div.sv]
// ============================================================================
// crg_div - pipelined restoring divider
// One quotient bit per stage; quotient known to stay below 2^Q_W.
// ============================================================================
module crg_div
    import crg_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [ROOT_W-1:0] den,
    output logic [Q_W-1:0]    quot
);

    logic [NUM_W-1:0]  rem_reg [Q_W];
    logic [Q_W-1:0]    q_reg   [Q_W];
    logic [ROOT_W-1:0] den_reg [Q_W];

    logic [NUM_W-1:0]  rem_cur [Q_W];
    logic [Q_W-1:0]    q_cur   [Q_W];
    logic [ROOT_W-1:0] den_cur [Q_W];
    logic [NUM_W:0]    diff    [Q_W];

    always_comb begin
        for (int i = 0; i < Q_W; i++) begin
            if (i == 0) begin
                rem_cur[i] = num;
                q_cur[i]   = '0;
                den_cur[i] = den;
            end else begin
                rem_cur[i] = rem_reg[i-1];
                q_cur[i]   = q_reg[i-1];
                den_cur[i] = den_reg[i-1];
            end
            diff[i] = {1'b0, rem_cur[i]} - ((NUM_W + 1)'(den_cur[i]) << (Q_W - 1 - i));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < Q_W; i++) begin
                // no borrow: remainder covers the shifted divisor
                if (!diff[i][NUM_W]) begin
                    rem_reg[i] <= diff[i][NUM_W-1:0];
                    q_reg[i]   <= q_cur[i] | (Q_W'(1) << (Q_W - 1 - i));
                end else begin
                    rem_reg[i] <= rem_cur[i];
                    q_reg[i]   <= q_cur[i];
                end
                den_reg[i] <= den_cur[i];
            end
        end
    end

    assign quot = q_reg[Q_W-1];

endmodule

[verif/camera_ray_generator_tb.sv]
// ----------------------------------------------------------------------------
// camera_ray_generator_tb - self-checking bench for the primary ray generator
// Drives pixel transfers under several camera set-ups. A bit-accurate
// predictor computes each ray, and every output transfer is checked field by
// field, in order. Both channels stall at random, with one long output
// hold-off and one source pause.
// ----------------------------------------------------------------------------
module camera_ray_generator_tb;
    import crg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 73;
    localparam int SETTLE     = LATENCY + 10;
    localparam int HOLD_LEN   = 300;   // long output hold-off, in cycles
    localparam int STALL_MAX  = 4000;  // cycles without any transfer

    typedef struct packed {
        logic [2:0][WORD_W-1:0] origin;
        logic [2:0][WORD_W-1:0] dir;
        logic                   degen;
    } ray_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;   // pixel_col, pixel_row
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;        // origin_x/y/z, dir_x/y/z
    logic                  m_tuser;        // degenerate

    camera_ray_generator dut (.*);

    // Bench copy of the register file and the rays still in flight
    logic [63:0] cam_regs [NUM_REGS];
    logic [63:0] cam_next [NUM_REGS];
    ray_t        rays_pending [$];
    int          errors = 0;
    int          idle_cycles = 0;

    // Channel behavior knobs
    bit src_gaps  = 1'b1;
    bit sink_gaps = 1'b1;
    bit hold_req  = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint sx32(logic [31:0] u);
        return longint'(signed'(u));
    endfunction

    function automatic longint cam_mat(int r, int c);
        logic [63:0] w;
        w = cam_regs[r * 2 + (c >> 1)];
        return (c & 1) ? sx32(w[31:0]) : sx32(w[63:32]);
    endfunction

    // Pixel center on the canvas, rounded half up, then saturated
    function automatic longint canvas_coord(longint half, int idx, longint pitch);
        longint t;
        t = 2 * half - longint'(2 * idx + 1) * pitch;
        t = (t + 1) >>> 1;
        if (t > 64'sd2147483647)  t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return t;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic ray_t predict_ray(int col, int row);
        ray_t            r;
        longint          w [3];
        longint          d [3];
        longint unsigned mag [3];
        longint unsigned mx, sq, len_root, q;
        longint          pitch;
        int              blen;
        pitch = longint'({32'd0, cam_regs[REG_PITCH][31:0]});
        w[0] = canvas_coord(sx32(cam_regs[REG_HALF][63:32]), col, pitch);
        w[1] = canvas_coord(sx32(cam_regs[REG_HALF][31:0]), row, pitch);
        w[2] = -(64'sd1 << FRAC_BITS);
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = ((cam_mat(i, 0) * w[0]) >>> 2) + ((cam_mat(i, 1) * w[1]) >>> 2)
                 + ((cam_mat(i, 2) * w[2]) >>> 2);
            mag[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
            if (mag[i] > mx) mx = mag[i];
            r.origin[i] = cam_mat(i, 3);
            r.dir[i] = '0;
        end
        r.degen = (mx == 0);
        if (!r.degen) begin
            blen = 0;
            for (int k = 0; k < 64; k++) if (mx[k]) blen = k + 1;
            sq = 0;
            // common power-of-two scale: largest magnitude into [2^29, 2^30)
            for (int i = 0; i < 3; i++) begin
                if (blen > 30) mag[i] >>= (blen - 30);
                else           mag[i] <<= (30 - blen);
                sq += mag[i] * mag[i];
            end
            len_root = int_sqrt(sq);
            for (int i = 0; i < 3; i++) begin
                q = ((mag[i] << 30) + (len_root >> 1)) / len_root;
                if (q > (64'd1 << 30)) q = 64'd1 << 30;   // unit overshoot clamp
                r.dir[i] = (d[i] < 0) ? -q[31:0] : q[31:0];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Output checker: every m_ transfer against the oldest pending ray
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        $display("[%0t] %s: expected %h, got %h", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    always @(posedge aclk) begin
        ray_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (rays_pending.size() == 0) begin
                report_mismatch("unexpected ray", '0, m_tdata[31:0]);
            end else begin
                exp_r = rays_pending.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (m_tdata[32*i +: 32] !== exp_r.origin[i])
                        report_mismatch($sformatf("origin[%0d]", i), exp_r.origin[i],
                                        m_tdata[32*i +: 32]);
                    if (m_tdata[32*(i+3) +: 32] !== exp_r.dir[i])
                        report_mismatch($sformatf("dir[%0d]", i), exp_r.dir[i],
                                        m_tdata[32*(i+3) +: 32]);
                end
                if (m_tuser !== exp_r.degen)
                    report_mismatch("degenerate", 32'(exp_r.degen), 32'(m_tuser));
            end
        end
    end

    // Watchdog: too long without a transfer on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("camera_ray_generator: mismatch");
            $finish;
        end
    end

    // Output side ready pattern; one NBA per iteration
    initial begin
        @(posedge aclk);
        wait (aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_req = 1'b0;
            end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------
    // One pixel transfer; the ray is predicted at the accepting edge
    task automatic send_pixel(int col, int row);
        s_tvalid <= 1'b1;
        s_tdata  <= {row[COORD_BITS-1:0], col[COORD_BITS-1:0]};
        do @(posedge aclk); while (!s_tready);
        rays_pending.push_back(predict_ray(col & 12'hFFF, row & 12'hFFF));
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // Source goes quiet until every ray is back and the pipe has emptied
    task automatic drain();
        s_tvalid <= 1'b0;
        while (rays_pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write all eight registers from cam_next, back to back; block is idle
    task automatic load_camera();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= cfg_idx_t'(i);
            cfg_wdata <= cam_next[i];
            @(posedge aclk);
            cam_regs[i] = (i == REG_PITCH) ? {32'd0, cam_next[i][31:0]} : cam_next[i];
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_small(int bits);
        return 32'(sx32($urandom) >>> (32 - bits));
    endfunction

    // Random camera: 0 anything, 1 plausible camera, 2 zero linear part
    task automatic pick_camera(int kind);
        for (int i = 0; i < NUM_REGS; i++) cam_next[i] = rand64();
        if (kind == 1) begin
            for (int r = 0; r < 3; r++) begin
                cam_next[2*r]   = {rand_small(18), rand_small(18)};
                cam_next[2*r+1] = {rand_small(18), $urandom};
            end
            cam_next[REG_PITCH] = {$urandom, 32'($urandom_range(0, 4096))};
            cam_next[REG_HALF]  = {rand_small(25), rand_small(25)};
        end else if (kind == 2) begin
            for (int r = 0; r < 3; r++) begin
                cam_next[2*r] = '0;
                cam_next[2*r+1][63:32] = '0;
            end
        end
    endtask

    // Raster runs of random length with random content, plus lone pixels
    task automatic random_pixels(int count);
        int col, row, run;
        while (count > 0) begin
            col = $urandom_range(0, 4095);
            row = $urandom_range(0, 4095);
            run = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 32);
            for (int k = 0; k < run && count > 0; k++, count--)
                send_pixel((col + k) & 12'hFFF, row);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset camera: identity, unit pitch, zero half extents
    task automatic test_reset_camera();
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(1, 2048);
        drain();
    endtask

    task automatic test_directed();
        // zero linear part: every direction sum is zero
        for (int i = 0; i < NUM_REGS; i++) cam_next[i] = '0;
        cam_next[REG_ROW0_ZW] = 64'h0000_0000_8000_0000;
        cam_next[REG_ROW1_ZW] = 64'h0000_0000_7FFF_FFFF;
        cam_next[REG_ROW2_ZW] = 64'h0000_0000_FFFF_FFFF;
        cam_next[REG_PITCH]   = 64'hFFFF_FFFF_0001_0000;
        load_camera();
        send_pixel(0, 0);
        send_pixel(4095, 0);
        drain();

        // canvas overflow both ways: huge pitch, extreme half extents
        cam_next[REG_ROW0_XY] = {ONE_Q, 32'd0};
        cam_next[REG_ROW1_XY] = {32'd0, ONE_Q};
        cam_next[REG_ROW2_ZW] = {ONE_Q, 32'h1234_5678};
        cam_next[REG_PITCH]   = 64'h0000_0000_FFFF_FFFF;
        cam_next[REG_HALF]    = 64'h7FFF_FFFF_8000_0000;
        load_camera();
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(2048, 1);
        drain();

        // zero pitch: all pixels land on the half-extent point
        cam_next[REG_PITCH] = 64'd0;
        cam_next[REG_HALF]  = 64'h8000_0000_7FFF_FFFF;
        load_camera();
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        drain();

        // extreme matrix words: largest products and sums
        cam_next[REG_ROW0_XY] = 64'h7FFF_FFFF_7FFF_FFFF;
        cam_next[REG_ROW0_ZW] = 64'h8000_0000_7FFF_FFFF;
        cam_next[REG_ROW1_XY] = 64'h8000_0000_8000_0000;
        cam_next[REG_ROW1_ZW] = 64'h7FFF_FFFF_8000_0000;
        cam_next[REG_ROW2_XY] = 64'h7FFF_FFFF_8000_0000;
        cam_next[REG_ROW2_ZW] = 64'h8000_0000_FFFF_FFFF;
        cam_next[REG_PITCH]   = 64'h0000_0000_0000_0001;
        cam_next[REG_HALF]    = 64'h7FFF_FFFF_7FFF_FFFF;
        load_camera();
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(1234, 3210);
        drain();

        // direction in the x-z plane, small magnitudes: unit and overshoot edge
        for (int i = 0; i < NUM_REGS; i++) cam_next[i] = '0;
        cam_next[REG_ROW2_ZW] = {32'h0000_0001, 32'd0};
        cam_next[REG_ROW0_XY] = {32'h0000_0003, 32'd0};
        cam_next[REG_PITCH]   = 64'h0000_0000_0000_8000;
        cam_next[REG_HALF]    = 64'h0000_0800_0000_0800;
        load_camera();
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(4096 / 2 - 1, 7);
        send_pixel(2730, 1365);
        drain();
    endtask

    task automatic test_random_cameras();
        for (int p = 0; p < 8; p++) begin
            pick_camera(p == 3 ? 2 : (p % 3 == 0 ? 0 : 1));
            load_camera();
            random_pixels(110);
            drain();
        end
    endtask

    // Output held off long enough to fill the pipe and stall the input
    task automatic test_backpressure();
        pick_camera(1);
        load_camera();
        hold_req = 1'b1;
        random_pixels(150);
        // source pause until every ray has come back
        s_tvalid <= 1'b0;
        while (rays_pending.size() != 0) @(posedge aclk);
        random_pixels(60);
        drain();
    endtask

    // Last stretch at full rate on both channels
    task automatic test_full_rate();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        pick_camera(1);
        load_camera();
        random_pixels(100);
        drain();
    endtask

    initial begin
        for (int i = 0; i < NUM_REGS; i++) cam_regs[i] = '0;
        cam_regs[REG_ROW0_XY] = {ONE_Q, 32'd0};
        cam_regs[REG_ROW1_XY] = {32'd0, ONE_Q};
        cam_regs[REG_ROW2_ZW] = {ONE_Q, 32'd0};
        cam_regs[REG_PITCH]   = {32'd0, ONE_Q};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_camera();
        test_directed();
        test_random_cameras();
        test_backpressure();
        test_full_rate();

        if (errors == 0) begin
            $display("camera_ray_generator: match");
        end else begin
            $display("camera_ray_generator: mismatch");
        end
        $finish;
    end

endmodule
